FILE: design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the front end, the record queue and the
// back end of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned PART_W = 15;
  localparam int unsigned CONT_W = 6;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Record queue between front and back end.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Classification of a byte taken as the start of a character.
  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_SEQ,
    LEAD_BAD
  } u8d_lead_t;

  // All results that one input byte causes: one, or two when "two" is set.
  typedef struct packed {
    logic            two;
    logic [CP_W-1:0] cp0;
    logic            repl0;
    logic [CP_W-1:0] cp1;
    logic            repl1;
  } u8d_rec_t;

endpackage

FILE: design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder, top level
// Each byte's results are registered in the record queue and then in the output
// register before they reach the outputs; a second result of the same byte follows.
// Throughput: one byte per cycle while the record queue is not full; a byte with two
// results needs an extra beat, absorbed by the four-entry record queue. A synchronous
// reset (rst) closes any open sequence and empties the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel: one raw byte per beat.
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_buffer,
  input  logic                        in_valid,
  output logic                        in_ready,
  // Output channel: one decoded code point per beat.
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic                        replaced,
  output logic                        run_last,
  output logic                        out_valid,
  input  logic                        out_ready
);

  // The front end decodes each accepted byte in the same cycle and pushes a
  // record of its results, if any, into the queue. Bytes that only advance an
  // open sequence push nothing.
  logic                 push;
  logic                 q_full;
  u8d_pkg::u8d_rec_t    push_rec;

  // The back end drains the queue head, one result beat at a time.
  logic                 pop;
  logic                 head_valid;
  u8d_pkg::u8d_rec_t    head;

  u8d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .q_full        (q_full),
    .push          (push),
    .rec           (push_rec)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The output register in the back end separates the two sides: new bytes
  // keep flowing while a result beat waits to be taken, until the queue is full.
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .code_point (code_point),
    .replaced   (replaced),
    .run_last   (run_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

FILE: design/u8d_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle while the record queue is not full, tracks the
// open sequence and turns each byte into a record of the results it causes.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 push,
  output u8d_pkg::u8d_rec_t    rec
);

  logic [1:0]                   pending;
  logic [1:0]                   pending_next;
  logic [u8d_pkg::PART_W-1:0]   partial;
  logic [u8d_pkg::PART_W-1:0]   partial_next;
  logic                         accept;
  logic                         emit;
  logic                         is_cont;
  logic [1:0]                   pend_dec;
  logic [u8d_pkg::CP_W-1:0]     cont_val;
  u8d_pkg::u8d_lead_t           lead_kind;
  logic [1:0]                   lead_need;
  logic [4:0]                   lead_bits;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign pend_dec = pending - 2'd1;
  assign cont_val = {partial, data_byte[u8d_pkg::CONT_W-1:0]};

  // Lead byte classification.
  always_comb begin
    lead_kind = u8d_pkg::LEAD_BAD;
    lead_need = 2'd0;
    lead_bits = 5'd0;
    unique case (data_byte) inside
      [8'h00:8'h7F]: lead_kind = u8d_pkg::LEAD_ASCII;
      [8'hC0:8'hDF]: begin
        lead_kind = u8d_pkg::LEAD_SEQ;
        lead_need = 2'd1;
        lead_bits = data_byte[4:0];
      end
      [8'hE0:8'hEF]: begin
        lead_kind = u8d_pkg::LEAD_SEQ;
        lead_need = 2'd2;
        lead_bits = {1'b0, data_byte[3:0]};
      end
      [8'hF0:8'hF7]: begin
        lead_kind = u8d_pkg::LEAD_SEQ;
        lead_need = 2'd3;
        lead_bits = {2'b00, data_byte[2:0]};
      end
      default: lead_kind = u8d_pkg::LEAD_BAD;
    endcase
  end

  // Sequence tracking and record building.
  always_comb begin
    logic                     do_lead;
    logic                     lead_emit;
    logic [u8d_pkg::CP_W-1:0] lead_cp;
    logic                     lead_repl;
    pending_next = pending;
    partial_next = partial;
    emit         = 1'b0;
    rec          = '0;
    do_lead      = 1'b0;
    lead_emit    = 1'b0;
    lead_cp      = u8d_pkg::REPL_CP;
    lead_repl    = 1'b1;

    if (pending != 2'd0) begin
      if (is_cont) begin
        if (pend_dec == 2'd0) begin
          pending_next = 2'd0;
          partial_next = '0;
          emit         = 1'b1;
          rec.cp0      = cont_val;
        end else if (end_of_buffer) begin
          pending_next = 2'd0;
          partial_next = '0;
          emit         = 1'b1;
          rec.cp0      = u8d_pkg::REPL_CP;
          rec.repl0    = 1'b1;
        end else begin
          pending_next = pend_dec;
          partial_next = cont_val[u8d_pkg::PART_W-1:0];
        end
      end else begin
        // Sequence broken off: replace it, then decode this byte afresh.
        pending_next = 2'd0;
        partial_next = '0;
        emit         = 1'b1;
        rec.cp0      = u8d_pkg::REPL_CP;
        rec.repl0    = 1'b1;
        do_lead      = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      unique case (lead_kind)
        u8d_pkg::LEAD_ASCII: begin
          lead_emit = 1'b1;
          lead_cp   = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte};
          lead_repl = 1'b0;
        end
        u8d_pkg::LEAD_SEQ: begin
          if (end_of_buffer) begin
            lead_emit = 1'b1;
          end else begin
            pending_next = lead_need;
            partial_next = {{(u8d_pkg::PART_W-5){1'b0}}, lead_bits};
          end
        end
        default: lead_emit = 1'b1;
      endcase
      if (lead_emit) begin
        if (emit) begin
          rec.two   = 1'b1;
          rec.cp1   = lead_cp;
          rec.repl1 = lead_repl;
        end else begin
          emit      = 1'b1;
          rec.cp0   = lead_cp;
          rec.repl0 = lead_repl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
    end else if (accept) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

`ifndef SYNTHESIS
  // The end of a buffer always leaves no sequence open.
  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> pending == 2'd0)
    else $error("sequence left open after end of buffer");
`endif

endmodule

FILE: design/u8d_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder record queue
// Short FIFO of result records between the front end and the back end.
// ----------------------------------------------------------------------------
module u8d_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  u8d_pkg::u8d_rec_t    push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output u8d_pkg::u8d_rec_t    head
);

  u8d_pkg::u8d_rec_t            entries [u8d_pkg::QDEPTH];
  logic [u8d_pkg::QPTR_W-1:0]   wr_ptr;
  logic [u8d_pkg::QPTR_W-1:0]   rd_ptr;
  logic [u8d_pkg::QCNT_W-1:0]   count;

  assign full       = (count == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("record queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("record queue read while empty");
`endif

endmodule

FILE: design/u8d_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Unpacks each record into one or two result beats and holds them in the
// output register until they are taken.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  u8d_pkg::u8d_rec_t           head,
  output logic                        pop,
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic                        replaced,
  output logic                        run_last,
  output logic                        out_valid,
  input  logic                        out_ready
);

  logic idx;
  logic idx_next;
  logic load;
  logic last;

  assign load     = head_valid && (!out_valid || out_ready);
  assign last     = idx || !head.two;
  assign pop      = load && last;
  assign idx_next = load ? (!idx && head.two) : idx;

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= idx ? head.cp1 : head.cp0;
      replaced   <= idx ? head.repl1 : head.repl0;
      run_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // The second half of a record is only pending while its record is at the head.
  a_second_has_head: assert property (@(posedge clk) disable iff (rst)
    idx |-> head_valid && head.two)
    else $error("second result pending without a two-result record");
`endif

endmodule
